@@ rtl/xyz_to_rgb_exp_tonemap_unit_assert.svh @@
// ----------------------------------------------------------------------------
// XYZ to RGB tone map unit: assertion macros
// Shorthand for clocked assertions on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef XYZ_TO_RGB_EXP_TONEMAP_UNIT_ASSERT_SVH
`define XYZ_TO_RGB_EXP_TONEMAP_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define XTM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("xyztm: same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define XTM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("xyztm: next-cycle check failed");

`endif

@@ rtl/xyztm_pkg.sv @@
// ----------------------------------------------------------------------------
// xyztm_pkg
// Types, fixed-point formats, constants and stage layout of the XYZ to RGB
// exponential tone map pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package xyztm_pkg;

    // field formats
    localparam int IN_W    = 24;              // signed Q8.16 input
    localparam int FRAC_IN = 16;
    localparam int OUT_F   = 16;              // unsigned Q0.16 output
    localparam int GAIN_W  = 16;              // unsigned Q8.8 gain
    localparam int COEF_W  = 19;              // signed Q.16 matrix coefficient

    // datapath widths
    localparam int PROD_W = IN_W + COEF_W - 1;     // one coefficient product
    localparam int SUM_W  = IN_W + COEF_W;         // row sum in Q.32, |row| < 2^42
    localparam int T_W    = SUM_W - 1 - FRAC_IN;   // rounded positive channel
    localparam int A_W    = T_W + GAIN_W;          // channel times gain, Q.24
    localparam int AL_W   = 29;                    // unsaturated a fits here
    localparam int LIFT   = 8;                     // Q.24 -> Q.32
    localparam int AX_W   = AL_W + LIFT;           // argument in Q.32
    localparam int RC_W   = 9;                     // reciprocal of ln2
    localparam int Q_W    = 32;                    // Q.32 fraction
    localparam int N_W    = AL_W + RC_W - Q_W;     // exponent shift count

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    localparam logic [Q_W:0]     ONE_Q32   = 33'h1_0000_0000;
    localparam logic [Q_W-1:0]   LN2_Q32   = 32'd2977044472;
    // smallest a (Q.24) whose argument reaches 40*ln2
    localparam logic [AL_W-1:0]  SAT_A     = 29'd465163199;
    // floor(2^40 / LN2_Q32), quotient estimate is at most one low
    localparam logic [RC_W-1:0]  RECIP_LN2 = 9'd369;
    localparam logic [SUM_W-2:0] HALF_IN   = (SUM_W - 1)'(32768);
    localparam logic [Q_W:0]     HALF_OUT  = (Q_W + 1)'(1) << (Q_W - 1 - OUT_F);

    // Horner evaluation of exp(-r), one term per step
    localparam int EXP_TERMS = 13;

    // floor(x / k) = (x * DIV_M[k]) >> (32 + DIV_L[k]) for any 32-bit x
    localparam logic [Q_W:0] DIV_M [1:EXP_TERMS] = '{
        33'd4294967296, 33'd4294967296, 33'd5726623062, 33'd4294967296,
        33'd6871947674, 33'd5726623062, 33'd4908534053, 33'd4294967296,
        33'd7635497416, 33'd6871947674, 33'd6247225158, 33'd5726623062,
        33'd5286113596
    };
    localparam logic [2:0] DIV_L [1:EXP_TERMS] = '{
        3'd0, 3'd1, 3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    // pipeline stage layout
    localparam int ST_MAT     = 0;
    localparam int MAT_STAGES = 2;
    localparam int ST_RED     = ST_MAT + MAT_STAGES;
    localparam int RED_STAGES = 5;
    localparam int ST_EXP     = ST_RED + RED_STAGES;
    localparam int EXP_STAGES = 2 * EXP_TERMS + 1;
    localparam int ST_OUT     = ST_EXP + EXP_STAGES;
    localparam int NUM_STAGES = ST_OUT + 1;

    typedef logic signed [COEF_W-1:0] coef_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // XYZ to linear sRGB, rows red, green, blue; columns X, Y, Z
    localparam coef_t MAT_Q16 [3][3] = '{
        '{ 19'sd212368, -19'sd100739,  -19'sd32672},
        '{-19'sd63521,   19'sd122945,   19'sd2723 },
        '{ 19'sd3647,   -19'sd13372,    19'sd69292}
    };

    typedef struct packed {
        logic signed [IN_W-1:0] x_in;
        logic signed [IN_W-1:0] y_in;
        logic signed [IN_W-1:0] z_in;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_F-1:0] red_out;
        logic [OUT_F-1:0] green_out;
        logic [OUT_F-1:0] blue_out;
    } pix_out_t;

    // range-reduced channel handed to the exp pipeline
    typedef struct packed {
        logic           zero;   // channel was not positive
        logic           full;   // argument at or beyond 40*ln2
        logic [N_W-1:0] n;
        logic [Q_W-1:0] r;
    } red_t;

endpackage

`default_nettype wire

@@ rtl/xyz_to_rgb_exp_tonemap_unit.sv @@
// ----------------------------------------------------------------------------
// xyz_to_rgb_exp_tonemap_unit
// HDR CIE XYZ pixel to tone mapped sRGB-linear 1 - exp(-gain*c), Q0.16.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one XYZ pixel (signed Q8.16 each) per
//   transaction; out_valid/out_ready/out_data carry the red, green, blue
//   result (unsigned Q0.16), one result per input, in input order.
//   cfg_valid/cfg_ready/cfg_data writes the Q8.8 exposure gain; cfg_ready is
//   always high. Write it only while no pixel is in flight.
//   Depth: 35 register stages. Throughput is one pixel per clock while
//   out_ready is high, set by the fully pipelined 13-step Horner exp chain
//   (two stages per step, one multiplier each) per channel.
//   Reset clears all stage valid bits and loads the gain with 1.0.
//   When the receiver stalls, the result holds in the output register and
//   the stages behind it keep advancing into empty slots; in_ready falls
//   only once every stage holds a pixel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "xyz_to_rgb_exp_tonemap_unit_assert.svh"

module xyz_to_rgb_exp_tonemap_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire xyztm_pkg::pix_in_t             in_data,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output xyztm_pkg::pix_out_t                 out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [xyztm_pkg::GAIN_W-1:0]   cfg_data
);
    import xyztm_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] adv;
    logic [GAIN_W-1:0]     gain_reg;
    sum_t [2:0]            sum_data;
    red_t                  red_st [3];
    logic [OUT_F-1:0]      ch     [3];
    pix_out_t              out_reg;

    // gain register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            gain_reg <= cfg_data;
        end
    end

    // stage advance: a stage loads when out_ready is high or any stage at or after it is empty
    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_adv
        assign adv[i] = out_ready | ~(&vld_reg[NUM_STAGES-1:i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = vld_reg[ST_OUT];

    // datapath
    xyztm_matrix u_matrix (
        .clk      (clk),
        .adv      (adv[ST_MAT +: MAT_STAGES]),
        .in_data  (in_data),
        .sum_data (sum_data)
    );

    for (genvar c = 0; c < 3; c++)
    begin : g_lane
        xyztm_reduce u_reduce (
            .clk     (clk),
            .adv     (adv[ST_RED +: RED_STAGES]),
            .sum_in  (sum_data[c]),
            .gain    (gain_reg),
            .red_out (red_st[c])
        );

        xyztm_exp u_exp (
            .clk    (clk),
            .adv    (adv[ST_EXP +: EXP_STAGES]),
            .red_in (red_st[c]),
            .ch_out (ch[c])
        );
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (adv[ST_OUT])
        begin
            out_reg.red_out   <= ch[0];
            out_reg.green_out <= ch[1];
            out_reg.blue_out  <= ch[2];
        end
    end

    assign out_data = out_reg;

    // input backpressure only with every stage occupied and output stalled
    `XTM_ASSERT_SAME(a_stall_full, !in_ready, (&vld_reg) && !out_ready)
    // a pixel leaving the last compute stage lands in the output register
    `XTM_ASSERT_NEXT(a_hand_off, vld_reg[ST_OUT-1] && adv[ST_OUT], out_valid)
    // pixels in flight change only by accepted input and output transactions
    `XTM_ASSERT_NEXT(a_count, 1'b1, $countones(vld_reg) + $past(out_valid && out_ready) == $past($countones(vld_reg)) + $past(in_valid && in_ready))

endmodule

`default_nettype wire

@@ rtl/xyztm_matrix.sv @@
// ----------------------------------------------------------------------------
// xyztm_matrix
// 3x3 XYZ to linear RGB matrix: one stage of products, one stage of sums.
// ----------------------------------------------------------------------------
`default_nettype none

module xyztm_matrix (
    input  wire logic                                 clk,
    input  wire logic [xyztm_pkg::MAT_STAGES-1:0]     adv,
    input  wire xyztm_pkg::pix_in_t                   in_data,
    output xyztm_pkg::sum_t [2:0]                     sum_data
);
    import xyztm_pkg::*;

    logic signed [IN_W-1:0]   vin       [3];
    logic signed [PROD_W-1:0] prod_next [3][3];
    logic signed [PROD_W-1:0] prod_reg  [3][3];
    sum_t                     sum_next  [3];
    sum_t [2:0]               sum_reg;

    assign vin[0] = in_data.x_in;
    assign vin[1] = in_data.y_in;
    assign vin[2] = in_data.z_in;

    // coefficient products
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[r][c] = PROD_W'(vin[c]) * PROD_W'(MAT_Q16[r][c]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            prod_reg <= prod_next;
        end
    end

    // row sums, exact Q.32
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            sum_next[r] = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1])
                        + SUM_W'(prod_reg[r][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                sum_reg[r] <= sum_next[r];
            end
        end
    end

    assign sum_data = sum_reg;

endmodule

`default_nettype wire

@@ rtl/xyztm_reduce.sv @@
// ----------------------------------------------------------------------------
// xyztm_reduce
// One channel: round to Q.16, apply gain, split the argument into n*ln2 + r.
// ----------------------------------------------------------------------------
`default_nettype none

module xyztm_reduce (
    input  wire logic                                 clk,
    input  wire logic [xyztm_pkg::RED_STAGES-1:0]     adv,
    input  wire xyztm_pkg::sum_t                      sum_in,
    input  wire logic [xyztm_pkg::GAIN_W-1:0]         gain,
    output xyztm_pkg::red_t                           red_out
);
    import xyztm_pkg::*;

    logic                  pos_next;
    logic [SUM_W-2:0]      rnd;
    logic [T_W-1:0]        t_reg;
    logic                  pos_t_reg;

    logic [A_W-1:0]        a_next;
    logic [A_W-1:0]        a_reg;
    logic                  pos_a_reg;

    logic [AL_W+RC_W-1:0]  est;
    logic [N_W-1:0]        q0_reg;
    logic [AL_W-1:0]       al_reg;
    logic                  pos_q_reg;
    logic                  sat_q_reg;

    logic [AX_W-1:0]       qm;
    logic [AX_W-1:0]       diff;
    logic [Q_W:0]          r0_reg;
    logic [N_W-1:0]        q0_r_reg;
    logic                  pos_r_reg;
    logic                  sat_r_reg;

    logic                  ge;
    logic [Q_W:0]          r_sub;
    red_t                  st_next;
    red_t                  st_reg;

    // positive test and rounding to Q.16
    assign pos_next = !sum_in[SUM_W-1] && (sum_in != '0);
    assign rnd      = sum_in[SUM_W-2:0] + HALF_IN;

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            t_reg     <= rnd[SUM_W-2:FRAC_IN];
            pos_t_reg <= pos_next;
        end
    end

    // exposure gain, Q.16 * Q8.8 = Q.24
    assign a_next = A_W'(t_reg) * A_W'(gain);

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            a_reg     <= a_next;
            pos_a_reg <= pos_t_reg;
        end
    end

    // saturation test and quotient estimate by reciprocal
    assign est = (AL_W + RC_W)'(a_reg[AL_W-1:0]) * (AL_W + RC_W)'(RECIP_LN2);

    always_ff @(posedge clk)
    begin
        if (adv[2])
        begin
            q0_reg    <= est[AL_W+RC_W-1:Q_W];
            al_reg    <= a_reg[AL_W-1:0];
            pos_q_reg <= pos_a_reg;
            sat_q_reg <= (a_reg >= A_W'(SAT_A));
        end
    end

    // remainder of the estimate, below 2*ln2
    assign qm   = AX_W'(q0_reg) * AX_W'(LN2_Q32);
    assign diff = {al_reg, {LIFT{1'b0}}} - qm;

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            r0_reg    <= diff[Q_W:0];
            q0_r_reg  <= q0_reg;
            pos_r_reg <= pos_q_reg;
            sat_r_reg <= sat_q_reg;
        end
    end

    // one correction step
    assign ge    = (r0_reg >= {1'b0, LN2_Q32});
    assign r_sub = r0_reg - {1'b0, LN2_Q32};

    always_comb
    begin
        st_next.zero = !pos_r_reg;
        st_next.full = pos_r_reg && sat_r_reg;
        st_next.n    = ge ? q0_r_reg + N_W'(1) : q0_r_reg;
        st_next.r    = ge ? r_sub[Q_W-1:0] : r0_reg[Q_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv[4])
        begin
            st_reg <= st_next;
        end
    end

    assign red_out = st_reg;

endmodule

`default_nettype wire

@@ rtl/xyztm_exp.sv @@
// ----------------------------------------------------------------------------
// xyztm_exp
// One channel: exp(-r) by pipelined Horner steps, scale by 2^-n, form
// 1 - exp and round to the output format.
// ----------------------------------------------------------------------------
`default_nettype none

module xyztm_exp (
    input  wire logic                                 clk,
    input  wire logic [xyztm_pkg::EXP_STAGES-1:0]     adv,
    input  wire xyztm_pkg::red_t                      red_in,
    output logic [xyztm_pkg::OUT_F-1:0]               ch_out
);
    import xyztm_pkg::*;

    logic [Q_W:0]     p_src   [EXP_TERMS];
    red_t             st_src  [EXP_TERMS];
    logic [2*Q_W:0]   hp      [EXP_TERMS];
    logic [2*Q_W:0]   dq      [EXP_TERMS];
    logic [Q_W-1:0]   x_next  [EXP_TERMS];
    logic [Q_W:0]     p_next  [EXP_TERMS];

    logic [Q_W-1:0]   x_reg   [EXP_TERMS];
    red_t             xst_reg [EXP_TERMS];
    logic [Q_W:0]     p_reg   [EXP_TERMS];
    red_t             pst_reg [EXP_TERMS];

    logic [Q_W:0]     e_val;
    logic [Q_W:0]     m_reg;
    logic             zero_reg;
    logic             full_reg;
    logic [Q_W:0]     rs;
    logic [OUT_F:0]   y_val;

    // Horner step for term k: p = 1 - floor(floor(r*p) / k)
    always_comb
    begin
        p_src[0]  = ONE_Q32;
        st_src[0] = red_in;
        for (int j = 1; j < EXP_TERMS; j++)
        begin
            p_src[j]  = p_reg[j-1];
            st_src[j] = pst_reg[j-1];
        end
        for (int j = 0; j < EXP_TERMS; j++)
        begin
            hp[j]     = (2*Q_W + 1)'(st_src[j].r) * (2*Q_W + 1)'(p_src[j]);
            x_next[j] = hp[j][2*Q_W-1:Q_W];
            dq[j]     = (2*Q_W + 1)'(x_reg[j]) * (2*Q_W + 1)'(DIV_M[EXP_TERMS-j]);
            p_next[j] = ONE_Q32
                      - (Q_W + 1)'(dq[j] >> (Q_W + int'(DIV_L[EXP_TERMS-j])));
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < EXP_TERMS; j++)
        begin
            if (adv[2*j])
            begin
                x_reg[j]   <= x_next[j];
                xst_reg[j] <= st_src[j];
            end
            if (adv[2*j+1])
            begin
                p_reg[j]   <= p_next[j];
                pst_reg[j] <= xst_reg[j];
            end
        end
    end

    // exp(-A) = exp(-r) * 2^-n, then 1 - exp
    assign e_val = p_reg[EXP_TERMS-1] >> pst_reg[EXP_TERMS-1].n;

    always_ff @(posedge clk)
    begin
        if (adv[2*EXP_TERMS])
        begin
            m_reg    <= ONE_Q32 - e_val;
            zero_reg <= pst_reg[EXP_TERMS-1].zero;
            full_reg <= pst_reg[EXP_TERMS-1].full;
        end
    end

    // round to output format, saturate at all ones, zero for a non-positive channel
    assign rs    = m_reg + HALF_OUT;
    assign y_val = rs[Q_W:Q_W-OUT_F];

    always_comb
    begin
        priority if (zero_reg)
        begin
            ch_out = '0;
        end
        else if (full_reg || y_val[OUT_F])
        begin
            ch_out = '1;
        end
        else
        begin
            ch_out = y_val[OUT_F-1:0];
        end
    end

endmodule

`default_nettype wire

@@ bench/xyz_to_rgb_exp_tonemap_unit_tb.sv @@
// ----------------------------------------------------------------------------
// xyz_to_rgb_exp_tonemap_unit_tb
// Self-checking bench for the XYZ to linear sRGB exponential tone map unit.
// A directed stimulus table covers zero, extreme, tiny and saturation-edge
// pixels. Random pixels follow under several exposure gains. Every result
// is checked against its table value or a bit-exact fixed-point model of
// the pipeline, and both handshakes see random idle bursts.
// ----------------------------------------------------------------------------

module xyz_to_rgb_exp_tonemap_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import xyztm_pkg::*;

    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 40;       // pipeline is 35 stages deep
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 190;
    localparam int N_PHASES     = 7;
    localparam int REPORT_MAX   = 10;
    localparam int N_DIRECTED   = 18;

    // fixed-point constants of the tone curve
    localparam longint unsigned Q32_UNIT     = 64'h1_0000_0000;
    localparam longint unsigned LN2_FIX      = 64'd2977044472;
    localparam int              HORNER_TERMS = 13;
    localparam int              SAT_SHIFT    = 40;
    localparam logic [15:0]     CH_FULL      = 16'hFFFF;
    localparam logic [15:0]     CH_ZERO      = 16'h0000;
    localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'd256;

    // XYZ to linear sRGB, signed Q.16, rows red/green/blue
    localparam longint RGB_COEF [3][3] = '{
        '{ 212368, -100739, -32672 },
        '{ -63521,  122945,   2723 },
        '{   3647,  -13372,  69292 }
    };

    // extremes first, then two small values; random gains, then unity, fill the rest
    localparam logic [GAIN_W-1:0] FIXED_GAINS [4] = '{16'd0, 16'hFFFF, 16'd1, 16'd64};

    typedef struct {
        pix_in_t  pix;
        bit       known;
        pix_out_t rgb;
    } vector_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    pix_in_t           in_data   = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    pix_out_t          out_data;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [GAIN_W-1:0] cfg_data  = '0;

    pix_out_t          rgb_expected_q [$];
    logic [GAIN_W-1:0] gain_shadow = UNITY_GAIN;
    vector_t           directed_tbl [N_DIRECTED];
    bit                calm        = 1'b0;
    int                ready_hold  = 0;
    int                errors      = 0;
    int                pixels_sent = 0;
    int                results_seen = 0;
    int                gains_used  = 0;
    int                cycles      = 0;

    xyz_to_rgb_exp_tonemap_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one channel: 1 - exp(-gain*s), range reduced, Horner series, Q0.16
    function automatic logic [15:0] tonemap_channel(input longint s,
                                                    input logic [GAIN_W-1:0] g);
        longint unsigned t, arg, n, r, p, e, y;
        int k;
        if (s <= 0)
            return CH_ZERO;
        t   = (unsigned'(s) + 64'd32768) >> 16;
        arg = (t * g) << 8;
        n   = arg / LN2_FIX;
        if (n >= SAT_SHIFT)
            return CH_FULL;
        r = arg - n * LN2_FIX;
        p = Q32_UNIT;
        for (k = HORNER_TERMS; k >= 1; k--)
            p = Q32_UNIT - ((r * p) >> 32) / unsigned'(64'(k));
        e = p >> n;
        y = (Q32_UNIT - e + 64'd32768) >> 16;
        return (y > 64'hFFFF) ? CH_FULL : y[15:0];
    endfunction

    // matrix then tone curve on all three channels
    function automatic pix_out_t predict_rgb(input pix_in_t px, input logic [GAIN_W-1:0] g);
        longint      comp [3];
        longint      s;
        logic [15:0] ch [3];
        int          c;
        comp[0] = longint'(px.x_in);
        comp[1] = longint'(px.y_in);
        comp[2] = longint'(px.z_in);
        for (c = 0; c < 3; c++)
        begin
            s = RGB_COEF[c][0] * comp[0] + RGB_COEF[c][1] * comp[1]
              + RGB_COEF[c][2] * comp[2];
            ch[c] = tonemap_channel(s, g);
        end
        return '{ch[0], ch[1], ch[2]};
    endfunction

    // magnitude of random width, so small and large values both show up
    function automatic logic [IN_W-1:0] rand_magnitude(input int width);
        logic [IN_W-1:0] v;
        v = IN_W'($urandom());
        return v & ((IN_W'(1) << width) - 1'b1);
    endfunction

    // mostly plausible HDR colors (positive XYZ of similar size), some noise
    function automatic pix_in_t rand_pixel();
        pix_in_t px;
        int      width;
        if ($urandom_range(0, 3) != 0)
        begin
            width   = $urandom_range(2, IN_W - 3);
            px.x_in = rand_magnitude(width + $urandom_range(0, 1));
            px.y_in = rand_magnitude(width + $urandom_range(0, 1));
            px.z_in = rand_magnitude(width + $urandom_range(0, 1));
        end
        else if ($urandom_range(0, 1) == 0)
        begin
            px.x_in = IN_W'($urandom());
            px.y_in = IN_W'($urandom());
            px.z_in = IN_W'($urandom());
        end
        else
        begin
            px.x_in = rand_magnitude($urandom_range(1, IN_W - 1));
            px.y_in = rand_magnitude($urandom_range(1, IN_W - 1));
            px.z_in = rand_magnitude($urandom_range(1, IN_W - 1));
            if ($urandom_range(0, 1) == 0) px.x_in = -px.x_in;
            if ($urandom_range(0, 1) == 0) px.y_in = -px.y_in;
            if ($urandom_range(0, 1) == 0) px.z_in = -px.z_in;
        end
        return px;
    endfunction

    // one input transaction; valid stays high on return so the next pixel
    // can follow back to back
    task automatic send_pixel(input pix_in_t px, input bit known, input pix_out_t typed);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 15);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data  <= px;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rgb_expected_q.push_back(known ? typed : predict_rgb(px, gain_shadow));
        pixels_sent++;
        @(negedge clk);
    endtask

    // gain write, only once the pipeline has drained
    task automatic write_gain(input logic [GAIN_W-1:0] g);
        in_valid <= 1'b0;
        while (rgb_expected_q.size() != 0)
            @(negedge clk);
        cfg_data  <= g;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        gain_shadow = g;
        gains_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver: random stall and ready bursts, steady ready at the end
    always @(negedge clk)
    begin
        if (calm)
            out_ready <= 1'b1;
        else if (ready_hold != 0)
            ready_hold <= ready_hold - 1;
        else if ($urandom_range(0, 2) == 0)
        begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 14);
        end
        else
        begin
            out_ready  <= 1'b1;
            ready_hold <= $urandom_range(0, 40);
        end
    end

    // result check against the oldest pending prediction
    always @(posedge clk)
    begin
        pix_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (rgb_expected_q.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("ERROR: %0t: result r/g/b %0d %0d %0d with nothing pending",
                             $time, out_data.red_out, out_data.green_out, out_data.blue_out);
            end
            else
            begin
                want = rgb_expected_q.pop_front();
                results_seen++;
                if (out_data.red_out !== want.red_out || out_data.green_out !== want.green_out
                    || out_data.blue_out !== want.blue_out)
                begin
                    errors++;
                    if (errors <= REPORT_MAX)
                        $display("ERROR: %0t: result %0d expected r/g/b %0d %0d %0d, got %0d %0d %0d",
                                 $time, results_seen, want.red_out, want.green_out,
                                 want.blue_out, out_data.red_out, out_data.green_out,
                                 out_data.blue_out);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results pending",
                     cycles, rgb_expected_q.size());
            $display("xyz_to_rgb_exp_tonemap_unit regression: fail");
            $finish;
        end
    end

    // stimulus
    initial
    begin
        int                i;
        int                ph;
        logic [GAIN_W-1:0] g;

        // zero, extremes, tiny values, white point, saturation edge, mixed signs and patterns
        directed_tbl = '{
            '{'{24'h000000, 24'h000000, 24'h000000}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h7FFFFF, 24'h800000, 24'h000000}, 1'b1, '{CH_FULL, CH_ZERO, CH_FULL}},
            '{'{24'h800000, 24'h7FFFFF, 24'h000000}, 1'b1, '{CH_ZERO, CH_FULL, CH_ZERO}},
            '{'{24'h800000, 24'h800000, 24'h800000}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF}, 1'b1, '{CH_FULL, CH_FULL, CH_FULL}},
            '{'{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF}, 1'b1, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h000001, 24'h000000, 24'h000000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h000000, 24'h000001, 24'h000000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h000000, 24'h000000, 24'h000001}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h00F353, 24'h010000, 24'h0116C2}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            // red just below and just at the large-argument threshold
            '{'{24'h088E5D, 24'h000000, 24'h000000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h088E5E, 24'h000000, 24'h000000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h000000, 24'h000000, 24'h7FFFFF}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h555555, 24'hAAAAAA, 24'h5A5A5A}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'hAAAAAA, 24'h555555, 24'hA5A5A5}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'hFF0000, 24'h000000, 24'h000000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h008000, 24'h008000, 24'h008000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}},
            '{'{24'h000000, 24'h000000, 24'hFF0000}, 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO}}
        };

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed rows run at the reset gain
        for (i = 0; i < N_DIRECTED; i++)
            send_pixel(directed_tbl[i].pix, directed_tbl[i].known, directed_tbl[i].rgb);

        // random pixels under a sweep of gains; last phase without idling
        for (ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph < 4)
                g = FIXED_GAINS[ph];
            else if (ph == N_PHASES - 1)
                g = UNITY_GAIN;
            else
                g = GAIN_W'($urandom_range(2, 16'hFFFE));
            if (ph == N_PHASES - 1)
                calm = 1'b1;
            write_gain(g);
            for (i = 0; i < PHASE_ITEMS; i++)
                send_pixel(rand_pixel(), 1'b0, '{CH_ZERO, CH_ZERO, CH_ZERO});
        end
        in_valid <= 1'b0;

        // drain, then watch for stray results
        while (rgb_expected_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("summary: %0d pixels sent, %0d results checked, %0d gain writes, %0d errors",
                 pixels_sent, results_seen, gains_used, errors);
        $display("summary: gains swept include 0, 1, 64, 256, 65535 and random values");
        if (errors == 0 && rgb_expected_q.size() == 0)
            $display("xyz_to_rgb_exp_tonemap_unit regression: pass");
        else
            $display("xyz_to_rgb_exp_tonemap_unit regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/xyztm_pkg.sv
rtl/xyztm_matrix.sv
rtl/xyztm_reduce.sv
rtl/xyztm_exp.sv
rtl/xyz_to_rgb_exp_tonemap_unit.sv
bench/xyz_to_rgb_exp_tonemap_unit_tb.sv
